// ===== hw/rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Sizes, codes and the sequencer state type shared by the heap queue files.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Number of keys the heap can hold.
  localparam int CAPACITY = 16;

  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Internal count and heap index widths follow from the capacity.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_RM_LD,
    ST_DN_CHK,
    ST_DN_CMP
  } state_t;

  // The heap is one-based; entry i lives at memory address i - 1.
  function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m;
    m = idx - IDX_W'(1);
    return m[ADDR_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
    return COUNT_W'(cnt);
  endfunction

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// Heap store RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/min_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue, top level
// A refused command is answered from idle. An insert climbs a level per UP_CHK/UP_CMP
// pair until its parent is no larger or it is the root; a remove loads root and last
// entry in RM_LD, ending there if it empties the queue, else sinks a level per DN_CHK/DN_CMP
// pair to a leaf or its place. One operation at a time, next accepted in the result's cycle.
// Reset (rst_n low, synchronous) empties the queue; the receiver cannot stall.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   in_key_in,
  output logic                                out_valid,
  output logic signed [mhpq_pkg::KEY_W-1:0]   out_key_out,
  output logic [mhpq_pkg::STATUS_W-1:0]       out_status,
  output logic [mhpq_pkg::COUNT_W-1:0]        out_count
);

  // The heap keeps its keys in a single RAM. Each operation carries the moving
  // key in a register (the "hole" technique): sift-up copies parents down into
  // the hole until the key fits, sift-down copies the smaller child up. Only
  // the final resting place receives the carried key, so each level costs one
  // read (issued in a CHK state) and one compare-and-write (the CMP state).
  // A read whose data is used never targets the entry written in the same
  // cycle, because the walk always moves away from the entry it has just written.

  mhpq_pkg::state_t state_r, state_nxt;

  logic [mhpq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [mhpq_pkg::CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] removed_r, removed_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  mhpq_pkg::status_t                 out_status_r, out_status_nxt;
  logic [mhpq_pkg::CNT_W-1:0]        out_cnt_r, out_cnt_nxt;

  // RAM ports.
  logic                               ram_we;
  logic [mhpq_pkg::ADDR_W-1:0]        ram_waddr;
  logic [mhpq_pkg::KEY_W-1:0]         ram_wdata;
  logic [mhpq_pkg::ADDR_W-1:0]        ram_raddr_a;
  logic [mhpq_pkg::ADDR_W-1:0]        ram_raddr_b;
  logic [mhpq_pkg::KEY_W-1:0]         ram_rdata_a;
  logic [mhpq_pkg::KEY_W-1:0]         ram_rdata_b;

  mhpq_ram #(
    .DATA_W (mhpq_pkg::KEY_W),
    .DEPTH  (mhpq_pkg::CAPACITY),
    .ADDR_W (mhpq_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Heap index arithmetic. Indices are one wider than the count so that the
  // children of the last entry can be formed without overflow.
  logic [mhpq_pkg::IDX_W-1:0] pos_idx;
  logic [mhpq_pkg::IDX_W-1:0] parent_idx;
  logic [mhpq_pkg::IDX_W-1:0] left_idx;
  logic [mhpq_pkg::IDX_W-1:0] right_idx;
  logic [mhpq_pkg::IDX_W-1:0] cnt_idx;
  logic                       has_left;
  logic                       has_right;
  logic                       pos_is_root;

  assign pos_idx     = {1'b0, pos_r};
  assign parent_idx  = pos_idx >> 1;
  assign left_idx    = {pos_r, 1'b0};
  assign right_idx   = {pos_r, 1'b1};
  assign cnt_idx     = {1'b0, cnt_r};
  assign has_left    = (left_idx <= cnt_idx);
  assign has_right   = (right_idx <= cnt_idx);
  assign pos_is_root = (pos_r == mhpq_pkg::CNT_ONE);

  // Key comparisons on the registered read data. During sift-up port A holds
  // the parent; during sift-down port A holds the left child, port B the right.
  logic signed [mhpq_pkg::KEY_W-1:0] rd_a;
  logic signed [mhpq_pkg::KEY_W-1:0] rd_b;
  logic parent_gt;
  logic dn_move;
  logic dn_pick_left;

  assign rd_a      = $signed(ram_rdata_a);
  assign rd_b      = $signed(ram_rdata_b);
  assign parent_gt = (rd_a > key_r);

  // With two children the key stops when it is no larger than both; with only
  // a left child it moves only when that child is strictly smaller.
  assign dn_move      = has_right ? !((key_r <= rd_a) && (key_r <= rd_b)) : (rd_a < key_r);
  assign dn_pick_left = !has_right || (rd_a < rd_b);

  logic accept;
  assign accept = start && (state_r == mhpq_pkg::ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == mhpq_pkg::OP_INSERT) begin
            if (cnt_r != mhpq_pkg::CNT_FULL) begin
              state_nxt = mhpq_pkg::ST_UP_CHK;
            end
          end else begin
            if (cnt_r != mhpq_pkg::CNT_ZERO) begin
              state_nxt = mhpq_pkg::ST_RM_LD;
            end
          end
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        state_nxt = pos_is_root ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_UP_CMP;
      end
      mhpq_pkg::ST_UP_CMP: begin
        state_nxt = parent_gt ? mhpq_pkg::ST_UP_CHK : mhpq_pkg::ST_IDLE;
      end
      mhpq_pkg::ST_RM_LD: begin
        state_nxt = (cnt_r == mhpq_pkg::CNT_ONE) ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_DN_CHK;
      end
      mhpq_pkg::ST_DN_CHK: begin
        state_nxt = has_left ? mhpq_pkg::ST_DN_CMP : mhpq_pkg::ST_IDLE;
      end
      mhpq_pkg::ST_DN_CMP: begin
        state_nxt = dn_move ? mhpq_pkg::ST_DN_CHK : mhpq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and result generation.
  always_comb begin
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = mhpq_pkg::idx_to_addr(pos_idx);
    ram_wdata      = key_r;
    ram_raddr_a    = mhpq_pkg::idx_to_addr(parent_idx);
    ram_raddr_b    = mhpq_pkg::idx_to_addr(right_idx);

    case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == mhpq_pkg::OP_INSERT) begin
            if (cnt_r == mhpq_pkg::CNT_FULL) begin
              out_valid_nxt  = 1'b1;
              out_key_nxt    = '0;
              out_status_nxt = mhpq_pkg::STATUS_FULL;
              out_cnt_nxt    = cnt_r;
            end else begin
              cnt_nxt = cnt_r + mhpq_pkg::CNT_ONE;
              pos_nxt = cnt_r + mhpq_pkg::CNT_ONE;
              key_nxt = in_key_in;
            end
          end else begin
            if (cnt_r == mhpq_pkg::CNT_ZERO) begin
              out_valid_nxt  = 1'b1;
              out_key_nxt    = '0;
              out_status_nxt = mhpq_pkg::STATUS_EMPTY;
              out_cnt_nxt    = cnt_r;
            end else begin
              // Fetch the root and the last entry together.
              ram_raddr_a = mhpq_pkg::idx_to_addr(mhpq_pkg::IDX_W'(1));
              ram_raddr_b = mhpq_pkg::idx_to_addr(cnt_idx);
            end
          end
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        if (pos_is_root) begin
          ram_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_key_nxt    = '0;
          out_status_nxt = mhpq_pkg::STATUS_OK;
          out_cnt_nxt    = cnt_r;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (parent_gt) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent_idx[mhpq_pkg::CNT_W-1:0];
        end else begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = '0;
          out_status_nxt = mhpq_pkg::STATUS_OK;
          out_cnt_nxt    = cnt_r;
        end
      end
      mhpq_pkg::ST_RM_LD: begin
        removed_nxt = rd_a;
        key_nxt     = rd_b;
        cnt_nxt     = cnt_r - mhpq_pkg::CNT_ONE;
        pos_nxt     = mhpq_pkg::CNT_ONE;
        if (cnt_r == mhpq_pkg::CNT_ONE) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = rd_a;
          out_status_nxt = mhpq_pkg::STATUS_OK;
          out_cnt_nxt    = mhpq_pkg::CNT_ZERO;
        end
      end
      mhpq_pkg::ST_DN_CHK: begin
        ram_raddr_a = mhpq_pkg::idx_to_addr(left_idx);
        ram_raddr_b = mhpq_pkg::idx_to_addr(right_idx);
        if (!has_left) begin
          ram_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_key_nxt    = removed_r;
          out_status_nxt = mhpq_pkg::STATUS_OK;
          out_cnt_nxt    = cnt_r;
        end
      end
      mhpq_pkg::ST_DN_CMP: begin
        ram_we = 1'b1;
        if (dn_move) begin
          ram_wdata = dn_pick_left ? ram_rdata_a : ram_rdata_b;
          pos_nxt   = dn_pick_left ? left_idx[mhpq_pkg::CNT_W-1:0]
                                   : right_idx[mhpq_pkg::CNT_W-1:0];
        end else begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = removed_r;
          out_status_nxt = mhpq_pkg::STATUS_OK;
          out_cnt_nxt    = cnt_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::ST_IDLE;
      cnt_r       <= mhpq_pkg::CNT_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    removed_r    <= removed_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // A transfer on the input side is possible whenever the sequencer is idle,
  // including the cycle in which the previous result is strobed out.
  assign busy        = (state_r != mhpq_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;
  assign out_status  = out_status_r;
  assign out_count   = mhpq_pkg::to_count(out_cnt_r);

endmodule

// ===== verif/min_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives inserts and remove-minimum commands through the start/busy port and
// checks every strobed result against a software copy of the heap.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  // Directed items come first, then exactly this many random ones.
  localparam int RANDOM_ITEMS = 1530;
  // The slowest legal run stays well inside this limit, so it is ample.
  localparam int CYCLE_LIMIT  = 400000;
  // Drain for longer than the longest operation takes.
  localparam int DRAIN_CYCLES = 24;

  // One expected result: what a single command should report.
  typedef struct {
    logic signed [KEY_W-1:0] key;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } heap_result_t;

  // Mirror of the heap contents. Each accepted transfer is applied to the
  // mirror straight away, and the outcome waits in a queue until the block
  // strobes its result.
  class heap_queue_mirror;
    logic signed [KEY_W-1:0] mirror_keys [1:CAPACITY];
    int unsigned             held;
    heap_result_t            owed_results [$];
    int                      errors;
    int                      n_insert, n_remove, n_full, n_empty, n_checked;

    function new();
      held = 0;
      errors = 0;
      n_insert = 0;
      n_remove = 0;
      n_full = 0;
      n_empty = 0;
      n_checked = 0;
    endfunction

    task report(input string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    function void note_transfer(input logic op, input logic signed [KEY_W-1:0] key_in);
      heap_result_t            res;
      logic signed [KEY_W-1:0] moving;
      int unsigned             pos, left, right, nxt;
      res.key = '0;
      res.status = STATUS_OK;
      if (op == OP_INSERT) begin
        n_insert++;
        if (held >= CAPACITY) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          // Append and climb until the parent is no larger, stopping at the root.
          held++;
          pos = held;
          while (pos > 1 && mirror_keys[pos / 2] > key_in) begin
            mirror_keys[pos] = mirror_keys[pos / 2];
            pos = pos / 2;
          end
          mirror_keys[pos] = key_in;
        end
      end else begin
        n_remove++;
        if (held == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          res.key = mirror_keys[1];
          moving = mirror_keys[held];
          held--;
          // Sink the former last entry from the root, looking only at
          // children that exist.
          pos = 1;
          while (held > 0) begin
            left = 2 * pos;
            right = left + 1;
            if (left > held) break;
            if (right <= held) begin
              if (moving <= mirror_keys[left] && moving <= mirror_keys[right]) break;
              nxt = (mirror_keys[left] < mirror_keys[right]) ? left : right;
            end else begin
              if (!(mirror_keys[left] < moving)) break;
              nxt = left;
            end
            mirror_keys[pos] = mirror_keys[nxt];
            pos = nxt;
          end
          if (held > 0) mirror_keys[pos] = moving;
        end
      end
      res.count = COUNT_W'(held);
      owed_results.push_back(res);
    endfunction

    task check_result(input logic signed [KEY_W-1:0] key, input status_t status,
                      input logic [COUNT_W-1:0] count);
      heap_result_t want;
      n_checked++;
      if (owed_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: key %0d status %0d count %0d",
                         key, status, count));
      end else begin
        want = owed_results.pop_front();
        if (key !== want.key)
          report($sformatf("key_out %0d, expected %0d", key, want.key));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (count !== want.count)
          report($sformatf("count %0d, expected %0d", count, want.count));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_op;
  logic signed [KEY_W-1:0] in_key_in;
  logic                    out_valid;
  logic signed [KEY_W-1:0] out_key_out;
  logic [STATUS_W-1:0]     out_status;
  logic [COUNT_W-1:0]      out_count;

  heap_queue_mirror heap_mirror;
  int               sender_idle_pct;
  int               cycles;

  min_heap_priority_queue_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_key_in   (in_key_in),
    .out_valid   (out_valid),
    .out_key_out (out_key_out),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor. Both the transfer and the result strobe are sampled at the rising
  // edge, so the values seen are the ones the block itself acts on. The result
  // is checked before a transfer at the same edge is noted, so that a result
  // can never be matched against the command that is only now being accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) heap_mirror.check_result(out_key_out, out_status, out_count);
      if (start && !busy) heap_mirror.note_transfer(in_op, in_key_in);
    end
  end

  // Half the keys are full-width random words, so that every bit toggles, and
  // the rest are small values for ties or the extremes of the range.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      5, 6: return KEY_W'($urandom_range(6)) - KEY_W'(3);
      7: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      8, 9: return KEY_W'($urandom_range(255)) - KEY_W'(128);
      default: return $urandom;
    endcase
  endfunction

  // Offers one command and returns at the falling edge after its transfer.
  // Before it, the sender may hold start low for a random number of cycles;
  // the fields carry junk meanwhile, which the block must ignore. Once start is
  // high it stays high until busy is low at a rising edge.
  task automatic transfer_item(input logic op, input logic signed [KEY_W-1:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      start     <= 1'b0;
      in_op     <= 1'($urandom_range(1));
      in_key_in <= pick_key();
      @(negedge clk);
    end
    start     <= 1'b1;
    in_op     <= op;
    in_key_in <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    int i;
    int seg_len;
    int insert_pct;
    int random_sent;
    int guard;
    logic op;

    heap_mirror = new();
    start = 1'b0;
    in_op = OP_INSERT;
    in_key_in = '0;
    rst_n = 1'b0;
    sender_idle_pct = 38;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: a remove on the empty queue, the extremes of the key
    // range, duplicate keys, a full drain that ends with another refused remove,
    // then one more insert and remove. Removes carry a junk key, which must have no effect.
    transfer_item(OP_REMOVE, 32'sh1234_5678);
    transfer_item(OP_INSERT, 32'sh7FFF_FFFF);
    transfer_item(OP_INSERT, 32'sh8000_0000);
    transfer_item(OP_INSERT, 32'sh0000_0000);
    transfer_item(OP_INSERT, -32'sd1);
    transfer_item(OP_INSERT, 32'sd1);
    transfer_item(OP_INSERT, 32'sd5);
    transfer_item(OP_INSERT, 32'sd5);
    transfer_item(OP_INSERT, -32'sd1);
    for (i = 0; i < 9; i++) transfer_item(OP_REMOVE, pick_key());
    transfer_item(OP_INSERT, 32'sd42);
    transfer_item(OP_REMOVE, 32'sh8000_0000);

    // Random part, in runs that lean towards filling, draining or churning the
    // heap, so that both the full and the empty refusals come up again and
    // again and sift paths of every depth are exercised. Before each command the
    // sender keeps idling with a chance of 38 in a hundred for the first third,
    // 54 for the second, and none at all for the last.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(4))
        0: insert_pct = 95;
        1: insert_pct = 8;
        2: insert_pct = 50;
        3: insert_pct = 65;
        default: insert_pct = 35;
      endcase
      seg_len = $urandom_range(40, 4);
      for (i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
        if (random_sent < RANDOM_ITEMS / 3) sender_idle_pct = 38;
        else if (random_sent < 2 * RANDOM_ITEMS / 3) sender_idle_pct = 54;
        else sender_idle_pct = 0;
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        transfer_item(op, pick_key());
        random_sent++;
      end
    end
    start <= 1'b0;

    // Wait for every outstanding result, then a little longer to catch any
    // stray strobe.
    guard = 0;
    while (heap_mirror.owed_results.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (heap_mirror.owed_results.size() != 0) begin
      void'(heap_mirror.owed_results.pop_front());
      heap_mirror.report("expected result never arrived");
    end

    $display("run covered %0d inserts (%0d refused as full) and %0d removes (%0d refused as empty)",
             heap_mirror.n_insert, heap_mirror.n_full, heap_mirror.n_remove, heap_mirror.n_empty);
    $display("%0d results checked in %0d cycles, %0d mismatches",
             heap_mirror.n_checked, cycles, heap_mirror.errors);
    if (heap_mirror.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== min_heap_priority_queue_top.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/min_heap_priority_queue_top.sv
verif/min_heap_priority_queue_top_tb.sv
